// ===== rtl/slfd_pkg.sv =====
// ----------------------------------------------------------------------------
// slfd_pkg: shared types and constants of the sync/length frame deframer
// Holds the input and result transaction layouts, result kinds, the phase
// encoding, the sync marker table and the register map.
// ----------------------------------------------------------------------------
package slfd_pkg;

  // Transaction layouts.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       last;
  } out_item_t;

  // Result kinds.
  localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
  localparam logic [2:0] KIND_EMPTY      = 3'd1;
  localparam logic [2:0] KIND_BAD_MARKER = 3'd2;
  localparam logic [2:0] KIND_TOO_LONG   = 3'd3;
  localparam logic [2:0] KIND_ABORTED    = 3'd4;

  // Deframer phase. The fourth code is never entered and acts as hunting.
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Sync marker. Entries past the fourteenth are zero.
  localparam int SYNC_IDX_W = 4;
  localparam logic [7:0] SYNC_PATTERN [16] = '{
    8'h00, 8'hFF, 8'h03, 8'hFE, 8'h4F, 8'h33, 8'h44, 8'h53,
    8'h2D, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h00, 8'h00
  };

  // Widths of the length path.
  localparam int MAX_LEN_W  = 21;
  localparam int LEN_FULL_W = 32;

  // Register map.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_PAYLOAD_LEN = 1'b0;
  localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RESET       = 21'd51200;

endpackage

// ===== rtl/sync_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_deframer: byte-stream frame recovery
// Finds sync-marked, length-prefixed frames and passes out their payload.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready/in_data) carries one received
// byte per transaction, with a restart flag that stands for a reconnect. The
// result channel (out_valid/out_ready/out_data) carries payload bytes with a
// last flag, and reports empty frames, bad markers, oversized lengths and
// aborted frames. Bytes that produce nothing (hunting, header) give no
// result transaction.
// An accepted byte is held in an input register and processed by the frame
// state machine once the output register can take a result; its result, if
// any, is then loaded into the output register. One byte is taken every
// cycle as long as the output register is empty or being read.
// When the receiver stalls with a result pending, the current byte waits in
// the input register and in_ready drops until out_ready returns.
// Reset returns the block to hunting for the marker, empties both registers
// and loads the maximum payload length with 51200. The length limit is set
// through the APB port at address 0 and must only change while idle.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer #(
  parameter int MARKER_LEN   = 14,
  parameter int LENGTH_BYTES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  slfd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output slfd_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [slfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic                           in_valid_r, in_valid_nxt;
  slfd_pkg::in_item_t             in_item_r, in_item_nxt;
  logic                           out_valid_r, out_valid_nxt;
  slfd_pkg::out_item_t            out_item_r, out_item_nxt;
  logic                           step_en;
  logic                           res_valid;
  slfd_pkg::out_item_t            res;
  logic [slfd_pkg::MAX_LEN_W-1:0] max_len;

  slfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  slfd_core #(
    .MARKER_LEN   (MARKER_LEN),
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (in_item_r),
    .max_len   (max_len),
    .res_valid (res_valid),
    .res       (res)
  );

  // The held byte is processed once the output register can take its result.
  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_item_nxt  = in_item_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
      in_item_nxt  = in_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (step_en && res_valid) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ===== rtl/slfd_cfg.sv =====
// ----------------------------------------------------------------------------
// slfd_cfg: configuration register block
// APB-style slave holding the maximum payload length register.
// ----------------------------------------------------------------------------
module slfd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [slfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [slfd_pkg::MAX_LEN_W-1:0]  max_len
);

  logic [slfd_pkg::CFG_ADDR_W-3:0] reg_idx;
  logic                            wr_en;
  logic [slfd_pkg::MAX_LEN_W-1:0]  max_len_r;
  logic [slfd_pkg::MAX_LEN_W-1:0]  max_len_nxt;

  // Byte lane bits of the address are ignored.
  assign reg_idx = paddr[slfd_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en && (reg_idx == slfd_pkg::REG_MAX_PAYLOAD_LEN)) begin
      max_len_nxt = pwdata[slfd_pkg::MAX_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= slfd_pkg::MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      slfd_pkg::REG_MAX_PAYLOAD_LEN: prdata = slfd_pkg::CFG_DATA_W'(max_len_r);
      default:                       prdata = '0;
    endcase
  end

  assign max_len = max_len_r;

endmodule

// ===== rtl/slfd_core.sv =====
// ----------------------------------------------------------------------------
// slfd_core: deframer state machine and header datapath
// Processes one byte per step and produces at most one result per step.
// ----------------------------------------------------------------------------
module slfd_core #(
  parameter int MARKER_LEN   = 14,
  parameter int LENGTH_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  slfd_pkg::in_item_t             item,
  input  logic [slfd_pkg::MAX_LEN_W-1:0] max_len,
  output logic                           res_valid,
  output slfd_pkg::out_item_t            res
);

  localparam int HDR_TOTAL = MARKER_LEN + LENGTH_BYTES;
  localparam int HP_W      = $clog2(HDR_TOTAL + 1);
  localparam int LEN_W     = 8 * LENGTH_BYTES;
  localparam logic [HP_W-1:0] MARK_LEN_C = HP_W'(MARKER_LEN);
  localparam logic [HP_W-1:0] HDR_LEN_C  = HP_W'(HDR_TOTAL);

  slfd_pkg::phase_t               phase_r, phase_nxt;
  logic                           after_frame_r, after_frame_nxt;
  logic [HP_W-1:0]                header_pos_r, header_pos_nxt;
  logic                           marker_bad_r, marker_bad_nxt;
  logic [LEN_W-1:0]               length_accum_r, length_accum_nxt;
  logic [slfd_pkg::MAX_LEN_W-1:0] payload_left_r, payload_left_nxt;

  logic                            busy;
  logic                            pay_last;
  logic                            in_marker;
  logic [7:0]                      sync_byte;
  logic                            byte_match;
  logic                            marker_bad_upd;
  logic [1:0]                      lane;
  logic [slfd_pkg::LEN_FULL_W-1:0] lane_shift;
  logic [LEN_W-1:0]                accum_upd;
  logic [HP_W-1:0]                 header_pos_inc;
  logic                            hdr_done;
  logic                            len_too_big;
  logic                            len_zero;

  // A header entered from hunting has its marker already matched and counts as
  // a frame in progress; one that follows a frame counts once it has a byte.
  assign busy = (phase_r == slfd_pkg::PH_PAYLOAD) ||
                ((phase_r == slfd_pkg::PH_HEADER) &&
                 (!after_frame_r || (header_pos_r != '0)));

  assign pay_last   = (payload_left_r <= slfd_pkg::MAX_LEN_W'(1));
  assign in_marker  = (header_pos_r < MARK_LEN_C);
  assign sync_byte  = slfd_pkg::SYNC_PATTERN[slfd_pkg::SYNC_IDX_W'(header_pos_r)];
  assign byte_match = (item.data_byte == sync_byte);
  assign marker_bad_upd = marker_bad_r || (in_marker && !byte_match);

  // Length bytes arrive least significant first.
  assign lane       = 2'(header_pos_r - MARK_LEN_C);
  assign lane_shift = slfd_pkg::LEN_FULL_W'(item.data_byte) << {lane, 3'b000};
  assign accum_upd  = in_marker ? length_accum_r
                                : (length_accum_r | LEN_W'(lane_shift));

  assign header_pos_inc = header_pos_r + HP_W'(1);
  assign hdr_done       = !(header_pos_inc < HDR_LEN_C);
  assign len_too_big    = (slfd_pkg::LEN_FULL_W'(accum_upd) >
                           slfd_pkg::LEN_FULL_W'(max_len));
  assign len_zero       = (accum_upd == '0);

  // Next state.
  always_comb begin
    phase_nxt        = phase_r;
    after_frame_nxt  = after_frame_r;
    header_pos_nxt   = header_pos_r;
    marker_bad_nxt   = marker_bad_r;
    length_accum_nxt = length_accum_r;
    payload_left_nxt = payload_left_r;
    if (step_en) begin
      if (item.restart) begin
        phase_nxt        = slfd_pkg::PH_HUNT;
        after_frame_nxt  = 1'b0;
        header_pos_nxt   = '0;
        marker_bad_nxt   = 1'b0;
        length_accum_nxt = '0;
        payload_left_nxt = '0;
      end else begin
        unique case (phase_r)
          slfd_pkg::PH_PAYLOAD: begin
            if (pay_last) begin
              phase_nxt        = slfd_pkg::PH_HEADER;
              after_frame_nxt  = 1'b1;
              header_pos_nxt   = '0;
              marker_bad_nxt   = 1'b0;
              length_accum_nxt = '0;
              payload_left_nxt = '0;
            end else begin
              payload_left_nxt = payload_left_r - slfd_pkg::MAX_LEN_W'(1);
            end
          end
          slfd_pkg::PH_HEADER: begin
            header_pos_nxt   = header_pos_inc;
            marker_bad_nxt   = marker_bad_upd;
            length_accum_nxt = accum_upd;
            if (hdr_done) begin
              if (marker_bad_upd || len_too_big) begin
                phase_nxt        = slfd_pkg::PH_HUNT;
                after_frame_nxt  = 1'b0;
                header_pos_nxt   = '0;
                marker_bad_nxt   = 1'b0;
                length_accum_nxt = '0;
                payload_left_nxt = '0;
              end else if (len_zero) begin
                after_frame_nxt  = 1'b1;
                header_pos_nxt   = '0;
                marker_bad_nxt   = 1'b0;
                length_accum_nxt = '0;
                payload_left_nxt = '0;
              end else begin
                phase_nxt        = slfd_pkg::PH_PAYLOAD;
                payload_left_nxt = slfd_pkg::MAX_LEN_W'(accum_upd);
              end
            end
          end
          default: begin
            phase_nxt = slfd_pkg::PH_HUNT;
            if (byte_match) begin
              header_pos_nxt = header_pos_inc;
              if (!(header_pos_inc < MARK_LEN_C)) begin
                phase_nxt        = slfd_pkg::PH_HEADER;
                after_frame_nxt  = 1'b0;
                header_pos_nxt   = MARK_LEN_C;
                marker_bad_nxt   = 1'b0;
                length_accum_nxt = '0;
              end
            end else begin
              header_pos_nxt = '0;
            end
          end
        endcase
      end
    end
  end

  // Result of the current step.
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = slfd_pkg::KIND_PAYLOAD;
    res.payload_byte = '0;
    res.last         = 1'b0;
    if (step_en) begin
      if (item.restart) begin
        res_valid = busy;
        res.kind  = slfd_pkg::KIND_ABORTED;
      end else begin
        unique case (phase_r)
          slfd_pkg::PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.payload_byte = item.data_byte;
            res.last         = pay_last;
          end
          slfd_pkg::PH_HEADER: begin
            if (hdr_done) begin
              if (marker_bad_upd) begin
                res_valid = 1'b1;
                res.kind  = slfd_pkg::KIND_BAD_MARKER;
              end else if (len_too_big) begin
                res_valid = 1'b1;
                res.kind  = slfd_pkg::KIND_TOO_LONG;
              end else if (len_zero) begin
                res_valid = 1'b1;
                res.kind  = slfd_pkg::KIND_EMPTY;
              end
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= slfd_pkg::PH_HUNT;
      after_frame_r  <= 1'b0;
      header_pos_r   <= '0;
      marker_bad_r   <= 1'b0;
      length_accum_r <= '0;
      payload_left_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      after_frame_r  <= after_frame_nxt;
      header_pos_r   <= header_pos_nxt;
      marker_bad_r   <= marker_bad_nxt;
      length_accum_r <= length_accum_nxt;
      payload_left_r <= payload_left_nxt;
    end
  end

endmodule

// ===== rtl/slfd_checker.sv =====
// ----------------------------------------------------------------------------
// slfd_checker: port-level checks of the deframer
// Watches the result channel and the input flow control over time.
// ----------------------------------------------------------------------------
module slfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input slfd_pkg::out_item_t out_data
);

  // A stalled result transaction holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Status results carry no byte and no last flag.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != slfd_pkg::KIND_PAYLOAD) |->
      (out_data.payload_byte == 8'h00) && !out_data.last)
    else $error("status result with payload fields set");

  // With no result pending the block always takes a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind sync_length_frame_deframer slfd_checker u_slfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
